// ===== rtl/spdr_pkg.sv =====
package spdr_pkg;
    localparam int MaxDataBytes = 15;
    localparam logic [7:0] FrameStart = 8'h50;
    localparam logic [7:0] FrameEnd   = 8'h45;
    localparam logic [7:0] LenFlip    = 8'hf0;
    localparam logic [7:0] ReplyLen   = 8'he1;
    localparam logic [31:0] CrcPoly   = 32'hedb88320;

    localparam logic [1:0] RegTest  = 2'd0;
    localparam logic [1:0] RegAlive = 2'd1;
    localparam logic [1:0] RegError = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;       // append the accepted byte
        logic drop_one;   // remove the leading byte
        logic drop_frame; // remove the whole frame at the front
        logic crc_init;   // start a CRC over the frame data
        logic crc_step;   // fold one data byte into the CRC
        logic decide;     // latch the reply code
        logic load_out;   // present a reply byte
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic enough;     // at least four bytes held
        logic start_ok;
        logic len_ok;
        logic complete;   // whole frame held
        logic end_ok;
        logic crc_done;   // all data bytes folded in
        logic full;
    } t_status;

    // One reflected CRC-32 byte update, eight dependent narrow steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] x;
        x = c ^ {24'd0, d};
        for (int b = 0; b < 8; b++) begin
            x = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
        end
        return x;
    endfunction
endpackage

// ===== rtl/spdr_datapath.sv =====
module spdr_datapath #(
    parameter int MAX_DATA_BYTES = spdr_pkg::MaxDataBytes
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_rx_byte,
    input  logic [7:0]        i_test_code,
    input  logic [7:0]        i_alive_code,
    input  logic [7:0]        i_error_code,
    input  logic [2:0]        i_out_idx,
    input  spdr_pkg::t_cmd    i_cmd,
    output spdr_pkg::t_status o_status,
    output logic [7:0]        o_tx_byte,
    output logic              o_reply_last
);
    localparam int Depth = MAX_DATA_BYTES + 4;
    localparam int CntW  = $clog2(Depth + 1);
    localparam int IdxW  = $clog2(Depth);

    // Window held as a shift line; index 0 is the oldest byte.
    logic [7:0]      r_win [Depth];
    logic [CntW-1:0] r_count;
    logic [31:0]     r_crc;
    logic [3:0]      r_pos;
    logic [7:0]      r_code;
    logic [7:0]      r_tx;
    logic            r_last;

    logic [7:0] len_x;
    logic [3:0] len;
    logic [CntW-1:0] frame_n;
    logic [7:0] end_byte;
    logic [7:0] chk_byte;
    logic [7:0] data_byte;
    logic [CntW-1:0] shift_n;

    assign len_x   = r_win[1] ^ spdr_pkg::LenFlip;
    assign len     = len_x[3:0];
    assign frame_n = CntW'(len) + CntW'(4);
    assign end_byte  = r_win[IdxW'(frame_n - CntW'(1))];
    assign chk_byte  = r_win[IdxW'(frame_n - CntW'(2))];
    assign data_byte = r_win[IdxW'(r_pos) + IdxW'(2)];

    always_comb begin
        o_status.enough   = r_count >= CntW'(4);
        o_status.start_ok = r_win[0] == spdr_pkg::FrameStart;
        o_status.len_ok   = (len_x[3:0] == len_x[7:4]) && (32'(len) <= 32'(MAX_DATA_BYTES));
        o_status.complete = r_count >= frame_n;
        o_status.end_ok   = end_byte == spdr_pkg::FrameEnd;
        o_status.crc_done = r_pos == len;
        o_status.full     = r_count == CntW'(Depth);
    end

    // Shift amount for the front of the window.
    always_comb begin
        shift_n = '0;
        if (i_cmd.drop_one)   shift_n = CntW'(1);
        if (i_cmd.drop_frame) shift_n = frame_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            if (i_cmd.push) begin
                r_win[IdxW'(r_count)] <= i_rx_byte;
                r_count <= r_count + CntW'(1);
            end else if (shift_n != '0) begin
                for (int k = 0; k < Depth; k++) begin
                    if (k + int'(shift_n) < Depth) r_win[k] <= r_win[k + int'(shift_n)];
                end
                r_count <= r_count - shift_n;
            end
        end
    end

    // CRC over the data bytes, one byte a cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.crc_init) begin
            r_crc <= '1;
            r_pos <= '0;
        end else if (i_cmd.crc_step) begin
            r_crc <= spdr_pkg::crc_byte(r_crc, data_byte);
            r_pos <= r_pos + 4'd1;
        end
        if (i_cmd.decide) begin
            if ((~r_crc[7:0]) != chk_byte || len == 4'd0 || r_win[2] != i_test_code)
                r_code <= i_error_code;
            else
                r_code <= i_alive_code;
        end
    end

    // Reply byte register.
    logic [31:0] code_crc;
    assign code_crc = ~spdr_pkg::crc_byte('1, r_code);
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_last <= 1'b0;
            case (i_out_idx)
                3'd0: r_tx <= spdr_pkg::FrameStart;
                3'd1: r_tx <= spdr_pkg::ReplyLen;
                3'd2: r_tx <= r_code;
                3'd3: r_tx <= code_crc[7:0];
                default: begin
                    r_tx   <= spdr_pkg::FrameEnd;
                    r_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_tx_byte    = r_tx;
    assign o_reply_last = r_last;
endmodule

// ===== rtl/spdr_ctrl.sv =====
module spdr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    output logic              o_tx_valid,
    input  logic              i_tx_ready,
    input  spdr_pkg::t_status i_status,
    output spdr_pkg::t_cmd    o_cmd,
    output logic [2:0]        o_out_idx
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_CRC, S_DECIDE, S_LOAD, S_SEND
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic       r_tx_valid, n_tx_valid;

    assign o_rx_ready = (r_state == S_IDLE) && !i_status.full;
    assign o_tx_valid = r_tx_valid;
    assign o_out_idx  = r_idx;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_tx_valid = r_tx_valid;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_status.full) begin
                    o_cmd.drop_one = 1'b1;
                end else if (i_rx_valid) begin
                    o_cmd.push = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_status.enough) begin
                    n_state = S_IDLE;
                end else if (!i_status.start_ok || !i_status.len_ok) begin
                    o_cmd.drop_one = 1'b1;
                end else if (!i_status.complete) begin
                    n_state = S_IDLE;
                end else if (!i_status.end_ok) begin
                    o_cmd.drop_one = 1'b1;
                end else begin
                    o_cmd.crc_init = 1'b1;
                    n_state = S_CRC;
                end
            end
            S_CRC: begin
                if (i_status.crc_done) n_state = S_DECIDE;
                else o_cmd.crc_step = 1'b1;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_idx = '0;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (r_idx == 3'd0) o_cmd.drop_frame = 1'b1;
                o_cmd.load_out = 1'b1;
                n_tx_valid = 1'b1;
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_tx_ready) begin
                    n_tx_valid = 1'b0;
                    if (r_idx == 3'd4) begin
                        n_state = S_SCAN;
                    end else begin
                        n_idx = r_idx + 3'd1;
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_tx_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_tx_valid <= n_tx_valid;
        end
    end

    a_valid_in_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_valid |-> r_state == S_SEND) else $error("reply valid outside send");
    a_no_rx_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_ready |-> !r_tx_valid) else $error("input taken while reply pending");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 3'd4) else $error("reply index out of range");
endmodule

// ===== rtl/serial_packet_deframe_reply.sv =====
// Channel | Signals                          | Direction
// rx      | i_rx_valid, o_rx_ready, i_rx_byte | in
// tx      | o_tx_valid, i_tx_ready, o_tx_byte, o_reply_last | out
// cfg     | i_cfg_we, i_cfg_idx, i_cfg_data  | in
// A byte that completes no frame is appended, then the scan state drops leading
// bytes one at a time while no valid frame begins at the front, and goes back to idle.
// A complete frame has its data bytes folded into the CRC one at a time, then the
// reply code is decided, and each reply byte is loaded and waits on the consumer.
// Reset is synchronous and active low; it empties the window and restores the codes.
module serial_packet_deframe_reply #(
    parameter int MAX_DATA_BYTES = spdr_pkg::MaxDataBytes
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_tx_valid,
    input  logic       i_tx_ready,
    output logic [7:0] o_tx_byte,
    output logic       o_reply_last,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    logic [7:0] r_test, r_alive, r_error;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_test  <= 8'd0;
            r_alive <= 8'd1;
            r_error <= 8'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spdr_pkg::RegTest:  r_test  <= i_cfg_data;
                spdr_pkg::RegAlive: r_alive <= i_cfg_data;
                spdr_pkg::RegError: r_error <= i_cfg_data;
                default: ;
            endcase
        end
    end

    spdr_pkg::t_cmd    cmd;
    spdr_pkg::t_status status;
    logic [2:0]        out_idx;

    spdr_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_rx_valid, .o_rx_ready, .o_tx_valid, .i_tx_ready,
        .i_status(status), .o_cmd(cmd), .o_out_idx(out_idx)
    );

    spdr_datapath #(.MAX_DATA_BYTES(MAX_DATA_BYTES)) u_dp (
        .i_clk, .i_rst_n, .i_rx_byte,
        .i_test_code(r_test), .i_alive_code(r_alive), .i_error_code(r_error),
        .i_out_idx(out_idx), .i_cmd(cmd), .o_status(status),
        .o_tx_byte, .o_reply_last
    );
endmodule
